// File: rtl/csdm_pkg.sv
// csdm_pkg: constants, types and tables for the concentric square-to-disk map
// used by csdm_front, csdm_div_cell, csdm_rot_cell and the top level
package csdm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int TABLE_LEN = 24;
  localparam int NUM_ITER = (ANGLE_ITERATIONS < TABLE_LEN) ? ANGLE_ITERATIONS : TABLE_LEN;

  // quotient bits: |ratio| <= 2^FRAC_BITS
  localparam int QW = FRAC_BITS + 2;
  localparam int DW = 17;                     // |a|,|b| up to 65536
  localparam int RW = DW + FRAC_BITS + 1;     // partial remainder / dividend width
  localparam int ZW = FRAC_BITS + 4;          // signed angle width
  localparam int XW = 28;                     // rotator datapath width
  localparam int MW = 26;                     // start magnitude width
  localparam int NUM_DIV = FRAC_BITS + 1;     // restoring steps

  localparam longint INV_GAIN_Q30 = 64'd652032875;

  typedef enum logic [3:0] {
    SEC_1 = 4'b0001,
    SEC_2 = 4'b0010,
    SEC_3 = 4'b0100,
    SEC_4 = 4'b1000
  } sector_t;

  // data passed along the divider chain
  typedef struct packed {
    logic                 vld;
    logic                 last;
    sector_t              sector;
    logic [DW-1:0]        r;
    logic [DW-1:0]        den;
    logic [RW-1:0]        rem;
    logic [QW-1:0]        quo;
    logic                 neg;     // quotient sign including sector negation
  } div_t;

  // data passed along the rotator chain
  typedef struct packed {
    logic                 vld;
    logic                 last;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  function automatic logic [63:0] atan_q30(input int i);
    logic [63:0] t;
    begin
      unique case (i)
        0: t = 64'd1073741824;  1: t = 64'd633866812;  2: t = 64'd334917813;
        3: t = 64'd170009513;   4: t = 64'd85334468;   5: t = 64'd42708923;
        6: t = 64'd21359677;    7: t = 64'd10680490;   8: t = 64'd5340327;
        9: t = 64'd2670173;     10: t = 64'd1335088;   11: t = 64'd667544;
        12: t = 64'd333772;     13: t = 64'd166886;    14: t = 64'd83443;
        15: t = 64'd41722;      16: t = 64'd20861;     17: t = 64'd10430;
        18: t = 64'd5215;       19: t = 64'd2608;      20: t = 64'd1304;
        21: t = 64'd652;        22: t = 64'd326;       default: t = 64'd163;
      endcase
      return t;
    end
  endfunction

  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic [63:0] t;
    begin
      t = (atan_q30(i) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      return $signed(t[ZW-1:0]);
    end
  endfunction

endpackage

// File: rtl/csdm_front.sv
// csdm_front: forms a, b, picks the sector and loads the divider chain
// depends on csdm_pkg
module csdm_front
  import csdm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [15:0]   unit_x,
  input  logic [15:0]   unit_y,
  input  logic          last_in,
  output div_t          out
);

  logic signed [17:0] a, b;
  logic [DW-1:0] abs_a, abs_b;
  div_t nxt;

  always_comb begin
    a = $signed({1'b0, unit_x, 1'b0}) - 18'sd65536;
    b = $signed({1'b0, unit_y, 1'b0}) - 18'sd65536;
    abs_a = a[17] ? DW'(-a) : DW'(a);
    abs_b = b[17] ? DW'(-b) : DW'(b);
    nxt = '0;
    nxt.vld = start;
    nxt.last = last_in;
    // dividend is the smaller magnitude scaled up by the fraction bits
    if (a > -b) begin
      if (a > b) begin
        nxt.sector = SEC_1; nxt.r = abs_a;
        nxt.rem = RW'(abs_b) << FRAC_BITS; nxt.den = abs_a; nxt.neg = b[17];
      end else begin
        nxt.sector = SEC_2; nxt.r = abs_b;
        nxt.rem = RW'(abs_a) << FRAC_BITS; nxt.den = abs_b;
        nxt.neg = ~a[17] & (a != 0);
      end
    end else begin
      if (a < b) begin
        nxt.sector = SEC_3; nxt.r = abs_a;
        nxt.rem = RW'(abs_b) << FRAC_BITS; nxt.den = abs_a;
        nxt.neg = ~b[17] & (b != 0);
      end else begin
        // b zero here means a zero: den 0, quotient forced to 0 below
        nxt.sector = SEC_4; nxt.r = abs_b;
        nxt.rem = RW'(abs_a) << FRAC_BITS; nxt.den = abs_b; nxt.neg = a[17];
      end
    end
    if (nxt.den == '0) nxt.rem = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) out.vld <= 1'b0;
    else     out.vld <= nxt.vld;
    out.last <= nxt.last;
    out.sector <= nxt.sector;
    out.r <= nxt.r;
    out.den <= nxt.den;
    out.rem <= nxt.rem;
    out.quo <= nxt.quo;
    out.neg <= nxt.neg;
  end

endmodule

// File: rtl/csdm_div_cell.sv
// csdm_div_cell: one restoring division step producing one quotient bit
// depends on csdm_pkg
module csdm_div_cell
  import csdm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  div_t in,
  input  logic [4:0] bit_idx,
  output div_t out
);

  logic [RW-1:0] trial;
  logic          take;

  always_comb begin
    trial = RW'(in.den) << bit_idx;
    take = (in.den != '0) && (in.rem >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) out.vld <= 1'b0;
    else     out.vld <= in.vld;
    out.last <= in.last;
    out.sector <= in.sector;
    out.r <= in.r;
    out.den <= in.den;
    out.neg <= in.neg;
    out.rem <= take ? in.rem - trial : in.rem;
    out.quo <= in.quo | (take ? (QW'(1) << bit_idx) : '0);
  end

endmodule

// File: rtl/csdm_rot_cell.sv
// csdm_rot_cell: one CORDIC rotation step with its fixed shift and angle
// depends on csdm_pkg
module csdm_rot_cell
  import csdm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  rot_t in,
  input  logic [4:0] shift,
  input  logic signed [ZW-1:0] step,
  output rot_t out
);

  logic signed [XW-1:0] dx, dy;

  always_comb begin
    dx = in.y >>> shift;
    dy = in.x >>> shift;
  end

  always_ff @(posedge clk) begin
    if (rst) out.vld <= 1'b0;
    else     out.vld <= in.vld;
    out.last <= in.last;
    if (!in.z[ZW-1]) begin
      out.x <= in.x - dx; out.y <= in.y + dy; out.z <= in.z - step;
    end else begin
      out.x <= in.x + dx; out.y <= in.y - dy; out.z <= in.z + step;
    end
  end

endmodule

// File: rtl/concentric_square_to_disk_map.sv
// concentric_square_to_disk_map: top level of the square-to-disk mapper
// depends on csdm_pkg, csdm_front, csdm_div_cell, csdm_rot_cell
//
// usage
//   a transaction is taken on every clock edge where start is high; busy is
//   tied low since every stage moves forward each cycle
//   unit_x/unit_y are Q0.16 square coordinates, last_in rides along
//   results appear on disk_x/disk_y/last_out with done high for one cycle
//   throughput: one transaction per cycle
//   pipeline registers in order: front, divider cells, gain multiply,
//     start vector, rotator cells, rounding
//   the chain of restoring divider cells and the chain of cordic cells hold
//   one cell per quotient bit and per rotation step
//   reset clears every valid bit; payload registers are not reset
//   the receiver cannot stall, done is a pure strobe
module concentric_square_to_disk_map
  import csdm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        unit_x,
  input  logic [15:0]        unit_y,
  input  logic               last_in,
  output logic               done,
  output logic signed [15:0] disk_x,
  output logic signed [15:0] disk_y,
  output logic               last_out
);

  assign busy = 1'b0;

  div_t dchain [NUM_DIV+1];
  rot_t rchain [NUM_ITER+1];

  csdm_front u_front (
    .clk(clk), .rst(rst), .start(start), .unit_x(unit_x), .unit_y(unit_y),
    .last_in(last_in), .out(dchain[0])
  );

  // divider: msb quotient bit first
  for (genvar i = 0; i < NUM_DIV; i++) begin : g_div
    csdm_div_cell u_cell (
      .clk(clk), .rst(rst), .in(dchain[i]),
      .bit_idx(5'(NUM_DIV - 1 - i)), .out(dchain[i+1])
    );
  end

  // gain multiply stage
  logic          m_vld, m_last;
  sector_t       m_sector;
  logic [MW-1:0] m_mag;
  logic signed [ZW-1:0] m_z;
  logic [47:0]   prod;
  div_t          dq;

  always_comb begin
    dq = dchain[NUM_DIV];
    prod = 48'(dq.r) * 48'(INV_GAIN_Q30) + (48'd1 << 21);
  end

  always_ff @(posedge clk) begin
    if (rst) m_vld <= 1'b0;
    else     m_vld <= dq.vld;
    m_last <= dq.last;
    m_sector <= dq.sector;
    m_mag <= prod[22 +: MW];
    m_z <= dq.neg ? -$signed(ZW'(dq.quo)) : $signed(ZW'(dq.quo));
  end

  // start vector by sector
  rot_t r0;
  always_comb begin
    r0.vld = m_vld;
    r0.last = m_last;
    r0.z = m_z;
    r0.x = '0;
    r0.y = '0;
    unique case (m_sector)
      SEC_1:   r0.x = $signed(XW'(m_mag));
      SEC_2:   r0.y = $signed(XW'(m_mag));
      SEC_3:   r0.x = -$signed(XW'(m_mag));
      default: r0.y = -$signed(XW'(m_mag));
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) rchain[0].vld <= 1'b0;
    else     rchain[0].vld <= r0.vld;
    rchain[0].last <= r0.last;
    rchain[0].x <= r0.x;
    rchain[0].y <= r0.y;
    rchain[0].z <= r0.z;
  end

  for (genvar i = 0; i < NUM_ITER; i++) begin : g_rot
    csdm_rot_cell u_cell (
      .clk(clk), .rst(rst), .in(rchain[i]), .shift(5'(i)),
      .step(atan_step(i)), .out(rchain[i+1])
    );
  end

  // round to q1.15 and clamp
  function automatic logic signed [15:0] to_q15(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] q;
    begin
      q = (v + XW'(256)) >>> 9;
      if (q > XW'(32767))        return 16'sd32767;
      else if (q < -XW'(32768))  return -16'sd32768;
      else                       return q[15:0];
    end
  endfunction

  rot_t rl;
  assign rl = rchain[NUM_ITER];

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= rl.vld;
    disk_x <= to_q15(rl.x);
    disk_y <= to_q15(rl.y);
    last_out <= rl.last;
  end

  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy asserted");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    rl.vld |=> done) else $error("result lost at output");
  a_front: assert property (@(posedge clk) disable iff (rst)
    start |=> dchain[0].vld) else $error("transaction lost at entry");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    dq.vld |-> dq.quo <= (QW'(1) << FRAC_BITS)) else $error("ratio exceeds one");

endmodule
